// File: sv/aabb_pkg.sv
package aabb_pkg;

    localparam int MAX_BOXES_DEF = 8;
    localparam int ID_W          = 16;
    localparam int POS_W         = 16;
    localparam int SIZE_W        = 15;
    localparam int SUM_W         = 18;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_TERM
    } state_t;

endpackage

// File: sv/aabb_ram.sv
module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/aabb_pairwise_overlap_finder_unit.sv
// Add beats are taken one per cycle and give no result; the box is written in that cycle
// unless the store is full. A run beat walks the store through one RAM read port: a head
// step per leading box, a scan step per pair and a terminator step, or only the terminator
// below two boxes; a stalled output beat holds the walk. Input is held off meanwhile.
// Reset clears the box count, the overflow flag, the sequencer and the output valid flag.
// Box contents are undefined after reset; only entries written since the last run are read.
module aabb_pairwise_overlap_finder_unit #(
    parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [aabb_pkg::ID_W-1:0]           entity_id,
    input  logic signed [aabb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [aabb_pkg::POS_W-1:0]   pos_y,
    input  logic [aabb_pkg::SIZE_W-1:0]         box_width,
    input  logic [aabb_pkg::SIZE_W-1:0]         box_height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                pair_found,
    output logic [aabb_pkg::ID_W-1:0]           first_entity,
    output logic [aabb_pkg::ID_W-1:0]           second_entity,
    output logic                                dropped_adds,
    output logic                                last
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int SUM_W = aabb_pkg::SUM_W;

    aabb_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    aabb_pkg::box_t   a_reg, a_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    pair_found_reg, pair_found_next;
    logic [aabb_pkg::ID_W-1:0] first_reg, first_next;
    logic [aabb_pkg::ID_W-1:0] second_reg, second_next;
    logic                    dropped_reg, dropped_next;
    logic                    last_reg, last_next;

    logic           in_fire;
    logic           can_emit;
    logic           full;
    logic           wr_en;
    logic           rd_en;
    logic [IDX_W-1:0] rd_addr;
    aabb_pkg::box_t wr_box;
    aabb_pkg::box_t b_box;
    logic           hit;
    logic           j_more;
    logic           i_more;
    logic           stall;

    logic signed [SUM_W-1:0] ax, ay, bx, by;
    logic signed [SUM_W-1:0] ax_end, ay_end, bx_end, by_end;

    assign in_ready = (state_reg == aabb_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;
    assign full     = (count_reg == CNT_W'(MAX_BOXES));

    assign wr_box.id     = entity_id;
    assign wr_box.pos_x  = pos_x;
    assign wr_box.pos_y  = pos_y;
    assign wr_box.width  = box_width;
    assign wr_box.height = box_height;
    assign wr_en = in_fire && (action == aabb_pkg::ACT_ADD) && !full;

    aabb_ram #(
        .WIDTH (aabb_pkg::BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_box),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (b_box)
    );

    assign ax = SUM_W'($signed(a_reg.pos_x));
    assign ay = SUM_W'($signed(a_reg.pos_y));
    assign bx = SUM_W'($signed(b_box.pos_x));
    assign by = SUM_W'($signed(b_box.pos_y));
    assign ax_end = ax + $signed({{(SUM_W-aabb_pkg::SIZE_W){1'b0}}, a_reg.width});
    assign ay_end = ay + $signed({{(SUM_W-aabb_pkg::SIZE_W){1'b0}}, a_reg.height});
    assign bx_end = bx + $signed({{(SUM_W-aabb_pkg::SIZE_W){1'b0}}, b_box.width});
    assign by_end = by + $signed({{(SUM_W-aabb_pkg::SIZE_W){1'b0}}, b_box.height});

    assign hit = !((ax >= bx_end) || (bx >= ax_end) || (ay >= by_end) || (by >= ay_end));

    assign j_more = (CNT_W'(j_reg) + CNT_W'(1)) < count_reg;
    assign i_more = (CNT_W'(i_reg) + CNT_W'(2)) < count_reg;
    assign stall  = hit && !can_emit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aabb_pkg::ST_IDLE:
            begin
                if (in_fire && (action == aabb_pkg::ACT_RUN))
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        state_next = aabb_pkg::ST_TERM;
                    end
                    else
                    begin
                        state_next = aabb_pkg::ST_HEAD;
                    end
                end
            end
            aabb_pkg::ST_HEAD:
            begin
                state_next = aabb_pkg::ST_SCAN;
            end
            aabb_pkg::ST_SCAN:
            begin
                if (!stall && !j_more)
                begin
                    if (i_more)
                    begin
                        state_next = aabb_pkg::ST_HEAD;
                    end
                    else
                    begin
                        state_next = aabb_pkg::ST_TERM;
                    end
                end
            end
            aabb_pkg::ST_TERM:
            begin
                if (can_emit)
                begin
                    state_next = aabb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aabb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        rd_en           = 1'b0;
        rd_addr         = i_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pair_found_next = pair_found_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        case (state_reg)
            aabb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (action == aabb_pkg::ACT_ADD)
                    begin
                        if (full)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        i_next  = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                end
            end
            aabb_pkg::ST_HEAD:
            begin
                a_next  = b_box;
                j_next  = i_reg + IDX_W'(1);
                rd_en   = 1'b1;
                rd_addr = i_reg + IDX_W'(1);
            end
            aabb_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        out_valid_next  = 1'b1;
                        pair_found_next = 1'b1;
                        first_next      = a_reg.id;
                        second_next     = b_box.id;
                        dropped_next    = 1'b0;
                        last_next       = 1'b0;
                    end
                    if (j_more)
                    begin
                        j_next  = j_reg + IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = j_reg + IDX_W'(1);
                    end
                    else if (i_more)
                    begin
                        i_next  = i_reg + IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = i_reg + IDX_W'(1);
                    end
                end
            end
            aabb_pkg::ST_TERM:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    pair_found_next = 1'b0;
                    first_next      = '0;
                    second_next     = '0;
                    dropped_next    = overflow_reg;
                    last_next       = 1'b1;
                    count_next      = '0;
                    overflow_next   = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aabb_pkg::ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        a_reg          <= a_next;
        pair_found_reg <= pair_found_next;
        first_reg      <= first_next;
        second_reg     <= second_next;
        dropped_reg    <= dropped_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign pair_found    = pair_found_reg;
    assign first_entity  = first_reg;
    assign second_entity = second_reg;
    assign dropped_adds  = dropped_reg;
    assign last          = last_reg;

endmodule

// File: sv/aabb_checker.sv
module aabb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      pair_found,
    input logic [aabb_pkg::ID_W-1:0] first_entity,
    input logic [aabb_pkg::ID_W-1:0] second_entity,
    input logic                      dropped_adds,
    input logic                      last
);

    // A pair beat is never the last beat and never carries the overflow flag.
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_found |-> !last && !dropped_adds)
        else $error("pair beat marked last or flagged dropped");

    // The terminator is the only beat without a pair, and it carries zero ids.
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pair_found |-> last && first_entity == '0 && second_entity == '0)
        else $error("terminator beat malformed");

    // No new item is taken while a run is still producing beats.
    a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_found && !out_ready |=> !in_ready)
        else $error("input accepted during a run");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_entity)
            && $stable(second_entity) && $stable(last))
        else $error("stalled output beat changed");

endmodule

bind aabb_pairwise_overlap_finder_unit aabb_checker u_aabb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pair_found    (pair_found),
    .first_entity  (first_entity),
    .second_entity (second_entity),
    .dropped_adds  (dropped_adds),
    .last          (last)
);

// File: dv/tb_aabb_pairwise_overlap_finder_unit.sv
`timescale 1ns / 100ps

module tb_aabb_pairwise_overlap_finder_unit;

    localparam int MAX_BOXES        = aabb_pkg::MAX_BOXES_DEF;
    localparam int ID_W             = aabb_pkg::ID_W;
    localparam int POS_W            = aabb_pkg::POS_W;
    localparam int SIZE_W           = aabb_pkg::SIZE_W;
    localparam int RANDOM_ITEMS     = 265;
    localparam int FULL_RATE_ITEMS  = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 64;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int MAX_SHOWN        = 10;

    typedef struct packed {
        logic            pair_found;
        logic [ID_W-1:0] first_entity;
        logic [ID_W-1:0] second_entity;
        logic            dropped_adds;
        logic            last;
    } overlap_report_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic                     action        = aabb_pkg::ACT_ADD;
    logic [ID_W-1:0]          entity_id     = '0;
    logic signed [POS_W-1:0]  pos_x         = '0;
    logic signed [POS_W-1:0]  pos_y         = '0;
    logic [SIZE_W-1:0]        box_width     = '0;
    logic [SIZE_W-1:0]        box_height    = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic                     pair_found;
    logic [ID_W-1:0]          first_entity;
    logic [ID_W-1:0]          second_entity;
    logic                     dropped_adds;
    logic                     last;

    aabb_pkg::box_t  frame_boxes [MAX_BOXES];
    int unsigned     frame_count    = 0;
    bit              frame_overflow = 1'b0;
    overlap_report_t expected_reports [$];

    bit idle_on        = 1'b1;
    bit long_hold_req  = 1'b0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int runs_sent      = 0;
    int boxes_stored   = 0;
    int boxes_refused  = 0;
    int pairs_seen     = 0;

    aabb_pairwise_overlap_finder_unit #(
        .MAX_BOXES(MAX_BOXES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .entity_id    (entity_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .box_width    (box_width),
        .box_height   (box_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pair_found   (pair_found),
        .first_entity (first_entity),
        .second_entity(second_entity),
        .dropped_adds (dropped_adds),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit boxes_collide(input aabb_pkg::box_t a, input aabb_pkg::box_t b);
        int ax;
        int ay;
        int bx;
        int by;
        ax = $signed(a.pos_x);
        ay = $signed(a.pos_y);
        bx = $signed(b.pos_x);
        by = $signed(b.pos_y);
        return !(ax >= bx + int'(b.width) || bx >= ax + int'(a.width) ||
                 ay >= by + int'(b.height) || by >= ay + int'(a.height));
    endfunction

    // Updates the frame store for one accepted beat and queues the reports a run produces.
    task automatic apply_frame_beat(input logic act, input aabb_pkg::box_t b);
        overlap_report_t rep;
        if (act == aabb_pkg::ACT_ADD)
        begin
            if (frame_count >= MAX_BOXES)
            begin
                frame_overflow = 1'b1;
                boxes_refused++;
            end
            else
            begin
                frame_boxes[frame_count] = b;
                frame_count++;
                boxes_stored++;
            end
        end
        else
        begin
            for (int i = 0; i < frame_count; i++)
            begin
                for (int j = i + 1; j < frame_count; j++)
                begin
                    if (boxes_collide(frame_boxes[i], frame_boxes[j]))
                    begin
                        rep = '{1'b1, frame_boxes[i].id, frame_boxes[j].id, 1'b0, 1'b0};
                        expected_reports = {expected_reports, rep};
                    end
                end
            end
            rep = '{1'b0, '0, '0, frame_overflow, 1'b1};
            expected_reports = {expected_reports, rep};
            frame_count    = 0;
            frame_overflow = 1'b0;
            runs_sent++;
        end
    endtask

    function automatic aabb_pkg::box_t make_box(input int id, input int x, input int y,
                                                input int w, input int h);
        aabb_pkg::box_t b;
        b.id     = id[ID_W-1:0];
        b.pos_x  = x[POS_W-1:0];
        b.pos_y  = y[POS_W-1:0];
        b.width  = w[SIZE_W-1:0];
        b.height = h[SIZE_W-1:0];
        return b;
    endfunction

    function automatic aabb_pkg::box_t random_box(input bit wide, input int cx, input int cy);
        aabb_pkg::box_t b;
        int             px;
        int             py;
        if (wide)
        begin
            b.id     = ID_W'($urandom_range(0, 65535));
            b.pos_x  = POS_W'($urandom_range(0, 65535));
            b.pos_y  = POS_W'($urandom_range(0, 65535));
            b.width  = SIZE_W'($urandom_range(0, 32767));
            b.height = SIZE_W'($urandom_range(0, 32767));
        end
        else
        begin
            px = cx + int'($urandom_range(0, 512)) - 256;
            py = cy + int'($urandom_range(0, 512)) - 256;
            b  = make_box($urandom_range(0, 65535), px, py,
                          $urandom_range(0, 256), $urandom_range(0, 256));
        end
        return b;
    endfunction

    task automatic send_beat(input logic act, input aabb_pkg::box_t b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        entity_id  <= b.id;
        pos_x      <= b.pos_x;
        pos_y      <= b.pos_y;
        box_width  <= b.width;
        box_height <= b.height;
        do
            @(posedge clk);
        while (!in_ready);
        apply_frame_beat(act, b);
    endtask

    task automatic wait_for_reports_drained();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_beat(aabb_pkg::ACT_RUN, make_box(0, 0, 0, 0, 0));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'hFFFF, -32768, -32768, 32767, 32767));
        send_beat(aabb_pkg::ACT_RUN, make_box(16'hFFFF, -1, -1, 32767, 32767));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'h0000, 32767, 32767, 32767, 32767));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'hFFFF, -32768, -32768, 32767, 32767));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'h1234, 0, 0, 0, 0));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'h5A5A, -16, -16, 16, 16));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'hA5A5, -16, -16, 17, 17));
        send_beat(aabb_pkg::ACT_ADD, make_box(16'h8001, -32768, 0, 32767, 1));
        send_beat(aabb_pkg::ACT_RUN, make_box(0, 0, 0, 0, 0));
        for (int k = 0; k <= MAX_BOXES; k++)
        begin
            send_beat(aabb_pkg::ACT_ADD, make_box(16'h0100 + k, 100, 100, 50, 50));
        end
        send_beat(aabb_pkg::ACT_RUN, make_box(0, 0, 0, 0, 0));
        send_beat(aabb_pkg::ACT_RUN, make_box(0, 0, 0, 0, 0));
        wait_for_reports_drained();
    endtask

    task automatic test_random_frames();
        int sent;
        int frame_size;
        int cx;
        int cy;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       frame_size = $urandom_range(0, 1);
                1:       frame_size = $urandom_range(MAX_BOXES, MAX_BOXES + 2);
                default: frame_size = $urandom_range(2, MAX_BOXES);
            endcase
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < frame_size; k++)
            begin
                send_beat(aabb_pkg::ACT_ADD, random_box($urandom_range(0, 7) == 0, cx, cy));
                sent++;
            end
            send_beat(aabb_pkg::ACT_RUN, random_box(1'b1, 0, 0));
            sent++;
        end
        wait_for_reports_drained();
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        repeat (3)
        begin
            for (int k = 0; k < MAX_BOXES; k++)
            begin
                send_beat(aabb_pkg::ACT_ADD, make_box($urandom_range(0, 65535),
                                                      $urandom_range(0, 32),
                                                      $urandom_range(0, 32), 100, 100));
            end
            send_beat(aabb_pkg::ACT_RUN, random_box(1'b1, 0, 0));
        end
        wait_for_reports_drained();
    endtask

    task automatic test_full_rate();
        int sent;
        int frame_size;
        int cx;
        int cy;
        idle_on = 1'b0;
        sent    = 0;
        while (sent < FULL_RATE_ITEMS)
        begin
            frame_size = $urandom_range(2, MAX_BOXES);
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < frame_size; k++)
            begin
                send_beat(aabb_pkg::ACT_ADD, random_box(1'b0, cx, cy));
                sent++;
            end
            send_beat(aabb_pkg::ACT_RUN, random_box(1'b1, 0, 0));
            sent++;
        end
        wait_for_reports_drained();
    endtask

    initial
    begin : sink_ready_driver
        int burst;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : report_checker
        overlap_report_t got;
        overlap_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{pair_found, first_entity, second_entity, dropped_adds, last};
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                begin
                    $display("ERROR: unexpected beat pair=%0b first=%h second=%h",
                             got.pair_found, got.first_entity, got.second_entity);
                    $display("       drop=%0b last=%0b", got.dropped_adds, got.last);
                end
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.pair_found === want.pair_found && got.pair_found === 1'b1)
                begin
                    pairs_seen++;
                end
                if (got.pair_found !== want.pair_found ||
                    got.first_entity !== want.first_entity ||
                    got.second_entity !== want.second_entity ||
                    got.dropped_adds !== want.dropped_adds ||
                    got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $display("ERROR: expected pair=%0b first=%h second=%h drop=%0b last=%0b",
                                 want.pair_found, want.first_entity, want.second_entity,
                                 want.dropped_adds, want.last);
                        $display("       actual   pair=%0b first=%h second=%h drop=%0b last=%0b",
                                 got.pair_found, got.first_entity, got.second_entity,
                                 got.dropped_adds, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_reports.size());
            $display("tb_aabb_pairwise_overlap_finder_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_frames();
        test_output_backpressure();
        test_full_rate();
        $display("Ran %0d frames: %0d boxes stored, %0d adds refused on a full store,",
                 runs_sent, boxes_stored, boxes_refused);
        $display("%0d overlapping pairs reported, %0d mismatches, %0d cycles",
                 pairs_seen, mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
        begin
            $display("tb_aabb_pairwise_overlap_finder_unit OK");
        end
        else
        begin
            $display("tb_aabb_pairwise_overlap_finder_unit NOT OK");
        end
        $finish;
    end

endmodule
